### design/encoder_speed_pid_controller_defines.svh
// ----------------------------------------------------------------------------
// Encoder speed PID controller: assertion macros
// Shared property shorthands for the controller's checks.
// ----------------------------------------------------------------------------
`ifndef ENCODER_SPEED_PID_CONTROLLER_DEFINES_SVH
`define ENCODER_SPEED_PID_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define ESPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define ESPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/espc_pkg.sv
// ----------------------------------------------------------------------------
// espc_pkg
// Widths, register indexes, sequencer states and limits of the encoder
// speed PID controller.
// ----------------------------------------------------------------------------
`default_nettype none

package espc_pkg;

    // field and datapath widths
    localparam int CNT_W      = 16;  // encoder count
    localparam int GAIN_W     = 16;  // Q8.8 gains, also the serial multiplier width
    localparam int TGT_W      = 26;  // target speed
    localparam int SPEED_W    = 25;  // measured speed
    localparam int ERR_W      = 27;  // speed error
    localparam int DIFF_W     = 28;  // error difference
    localparam int SUM_W      = 40;  // integrator
    localparam int ACC_W      = 58;  // drive accumulator
    localparam int FRAC_W     = 16;  // fraction bits dropped from the drive
    localparam int DRV_W      = 16;  // drive value and clamp limits
    localparam int BIT_W      = 4;   // serial bit counter, log2(GAIN_W)
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 26;

    // integrator saturation limits
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MAX = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MIN = 3'd5;

    // reset values of the clamp limits
    localparam logic signed [DRV_W-1:0] DRIVE_MAX_RST = {1'b0, {(DRV_W-1){1'b1}}};
    localparam logic signed [DRV_W-1:0] DRIVE_MIN_RST = {1'b1, {(DRV_W-1){1'b0}}};

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,   // waiting for a word
        ST_SPEED,  // serial count * scale
        ST_ERR,    // error, integrator, difference
        ST_MUL,    // serial gain products into the accumulator
        ST_ROUND,  // bias toward zero before the shift
        ST_OUT     // clamp and hand to the output register
    } t_state;

    // which gain term the serial multiplier works on
    typedef enum logic [1:0] {
        PH_P,
        PH_I,
        PH_D
    } t_phase;

endpackage

`default_nettype wire

### design/encoder_speed_pid_controller.sv
// ----------------------------------------------------------------------------
// encoder_speed_pid_controller
// Positional PID speed loop on a sampled encoder count, bit-serial datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one encoder count word per
//   control tick. Output channel (o_out_valid / i_out_stall) returns one word
//   per input: clamped drive, measured speed and a clamp flag.
//   Configuration: write target, gains and drive limits through i_cfg_we /
//   i_cfg_idx / i_cfg_data while no word is in flight; unknown indexes are
//   dropped.
//   Datapath: one shared 58-bit adder walks the 16 scale bits (speed) and
//   then 3 x 16 gain bits (PID terms), one bit per cycle, plus error,
//   rounding and clamp cycles.
//   A new word is taken only once the last one has reached the output
//   register; o_in_stall is high while a word is being worked on.
//   Reset clears the integrator and last error, loads register defaults
//   (gains 0, target 0, limits full range) and empties the output register.
//   A stalled output word holds; the next word may be accepted meanwhile and
//   waits in the final stage until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_speed_pid_controller #(
    parameter int unsigned FOLD_LIMIT     = 500,
    parameter int unsigned SPEED_SCALE_Q8 = 340
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // configuration
    input  wire logic                                  i_cfg_we,
    input  wire logic [espc_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [espc_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // input channel
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire logic [espc_pkg::CNT_W-1:0]            i_encoder_count,
    // output channel
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic signed [espc_pkg::DRV_W-1:0]          o_drive_value,
    output logic [espc_pkg::SPEED_W-1:0]               o_measured_speed,
    output logic                                       o_clamped
);

    `include "encoder_speed_pid_controller_defines.svh"

    localparam int CntW   = espc_pkg::CNT_W;
    localparam int GainW  = espc_pkg::GAIN_W;
    localparam int TgtW   = espc_pkg::TGT_W;
    localparam int SpeedW = espc_pkg::SPEED_W;
    localparam int ErrW   = espc_pkg::ERR_W;
    localparam int DiffW  = espc_pkg::DIFF_W;
    localparam int SumW   = espc_pkg::SUM_W;
    localparam int AccW   = espc_pkg::ACC_W;
    localparam int FracW  = espc_pkg::FRAC_W;
    localparam int DrvW   = espc_pkg::DRV_W;
    localparam int BitW   = espc_pkg::BIT_W;
    localparam int QW     = AccW - FracW;

    localparam logic [CntW-1:0]  FoldLim   = FOLD_LIMIT[CntW-1:0];
    localparam logic [GainW-1:0] SpeedScl  = SPEED_SCALE_Q8[GainW-1:0];
    localparam logic [AccW-1:0]  RoundBias = {{(AccW-FracW){1'b0}}, {FracW{1'b1}}};

    // configuration registers
    logic signed [TgtW-1:0]  r_target;
    logic [GainW-1:0]        r_gain_p;
    logic [GainW-1:0]        r_gain_i;
    logic [GainW-1:0]        r_gain_d;
    logic signed [DrvW-1:0]  r_drive_max;
    logic signed [DrvW-1:0]  r_drive_min;

    // control and loop state
    espc_pkg::t_state        r_state, n_state;
    espc_pkg::t_phase        r_phase, n_phase;
    logic [BitW-1:0]         r_bit, n_bit;
    logic signed [SumW-1:0]  r_sum;
    logic signed [ErrW-1:0]  r_prev;
    logic                    r_out_valid;

    // serial datapath
    logic signed [AccW-1:0]  r_acc, n_acc;
    logic signed [AccW-1:0]  r_mcand, n_mcand;
    logic [GainW-1:0]        r_mplier, n_mplier;
    logic [SpeedW-1:0]       r_speed;
    logic signed [DiffW-1:0] r_diff;

    // output register
    logic signed [DrvW-1:0]  r_drive_out;
    logic [SpeedW-1:0]       r_speed_out;
    logic                    r_clamped_out;

    logic                    w_in_accept;
    logic                    w_out_load;
    logic                    w_bit_last;
    logic [CntW-1:0]         w_fold;
    logic [AccW-1:0]         w_addend;
    logic signed [AccW-1:0]  w_add;
    logic [SpeedW-1:0]       w_speed;
    logic signed [ErrW-1:0]  w_err;
    logic signed [SumW:0]    w_sum_raw;
    logic signed [SumW-1:0]  w_sum_sat;
    logic signed [DiffW-1:0] w_diff;
    logic signed [QW-1:0]    w_q;
    logic signed [QW-1:0]    w_max_ext;
    logic signed [QW-1:0]    w_min_ext;
    logic signed [DrvW-1:0]  w_drive;
    logic                    w_clamp;

    // handshake
    assign w_in_accept = i_in_valid && (r_state == espc_pkg::ST_IDLE);
    assign w_out_load  = (r_state == espc_pkg::ST_OUT) && (!r_out_valid || !i_out_stall);
    assign w_bit_last  = (r_bit == {BitW{1'b1}});

    assign o_in_stall       = (r_state != espc_pkg::ST_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_drive_value    = r_drive_out;
    assign o_measured_speed = r_speed_out;
    assign o_clamped        = r_clamped_out;

    // reverse motion folds to a positive magnitude
    assign w_fold = (i_encoder_count > FoldLim) ? ~i_encoder_count : i_encoder_count;

    // shared adder: one serial partial product, or the round-toward-zero bias
    always_comb begin
        if (r_state == espc_pkg::ST_ROUND) begin
            w_addend = r_acc[AccW-1] ? RoundBias : '0;
        end else begin
            w_addend = r_mplier[0] ? r_mcand : '0;
        end
        w_add = r_acc + $signed(w_addend);
    end

    // speed saturation, error, integrator and error difference
    always_comb begin
        w_speed   = (|r_acc[AccW-1:SpeedW]) ? {SpeedW{1'b1}} : r_acc[SpeedW-1:0];
        w_err     = $signed({{(ErrW-TgtW){r_target[TgtW-1]}}, r_target})
                  - $signed({{(ErrW-SpeedW){1'b0}}, w_speed});
        w_sum_raw = $signed({r_sum[SumW-1], r_sum})
                  + $signed({{(SumW+1-ErrW){w_err[ErrW-1]}}, w_err});
        if (w_sum_raw[SumW] != w_sum_raw[SumW-1]) begin
            w_sum_sat = w_sum_raw[SumW] ? espc_pkg::SUM_MIN : espc_pkg::SUM_MAX;
        end else begin
            w_sum_sat = w_sum_raw[SumW-1:0];
        end
        w_diff    = $signed({w_err[ErrW-1], w_err}) - $signed({r_prev[ErrW-1], r_prev});
    end

    // drop fraction bits and clamp; drive_max is tested first
    always_comb begin
        w_q       = r_acc[AccW-1:FracW];
        w_max_ext = QW'(r_drive_max);
        w_min_ext = QW'(r_drive_min);
        priority if (w_q >= w_max_ext) begin
            w_drive = r_drive_max;
            w_clamp = 1'b1;
        end else if (w_q <= w_min_ext) begin
            w_drive = r_drive_min;
            w_clamp = 1'b1;
        end else begin
            w_drive = w_q[DrvW-1:0];
            w_clamp = 1'b0;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            espc_pkg::ST_IDLE:  if (w_in_accept) n_state = espc_pkg::ST_SPEED;
            espc_pkg::ST_SPEED: if (w_bit_last) n_state = espc_pkg::ST_ERR;
            espc_pkg::ST_ERR:   n_state = espc_pkg::ST_MUL;
            espc_pkg::ST_MUL: begin
                if (w_bit_last && (r_phase == espc_pkg::PH_D)) begin
                    n_state = espc_pkg::ST_ROUND;
                end
            end
            espc_pkg::ST_ROUND: n_state = espc_pkg::ST_OUT;
            espc_pkg::ST_OUT:   if (w_out_load) n_state = espc_pkg::ST_IDLE;
            default:            n_state = espc_pkg::ST_IDLE;
        endcase
    end

    // datapath controls per state
    always_comb begin
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_bit    = r_bit;
        n_phase  = r_phase;
        unique case (r_state)
            espc_pkg::ST_IDLE: begin
                // count * scale walks the scale bits
                n_acc    = '0;
                n_mcand  = AccW'(w_fold);
                n_mplier = SpeedScl;
                n_bit    = '0;
            end
            espc_pkg::ST_SPEED, espc_pkg::ST_MUL: begin
                n_acc    = w_add;
                n_mcand  = {r_mcand[AccW-2:0], 1'b0};
                n_mplier = {1'b0, r_mplier[GainW-1:1]};
                n_bit    = r_bit + 1'b1;
                if (w_bit_last && (r_state == espc_pkg::ST_MUL)) begin
                    unique case (r_phase)
                        espc_pkg::PH_P: begin
                            n_mcand  = AccW'(r_sum);
                            n_mplier = r_gain_i;
                            n_phase  = espc_pkg::PH_I;
                        end
                        espc_pkg::PH_I: begin
                            n_mcand  = AccW'(r_diff);
                            n_mplier = r_gain_d;
                            n_phase  = espc_pkg::PH_D;
                        end
                        espc_pkg::PH_D: n_phase = espc_pkg::PH_P;
                        default:        n_phase = espc_pkg::PH_P;
                    endcase
                end
            end
            espc_pkg::ST_ERR: begin
                // proportional term first
                n_acc    = '0;
                n_mcand  = AccW'(w_err);
                n_mplier = r_gain_p;
                n_bit    = '0;
                n_phase  = espc_pkg::PH_P;
            end
            espc_pkg::ST_ROUND: n_acc = w_add;
            espc_pkg::ST_OUT:   n_acc = r_acc;
            default:            n_acc = r_acc;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= espc_pkg::ST_IDLE;
            r_phase     <= espc_pkg::PH_P;
            r_bit       <= '0;
            r_sum       <= '0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
            r_target    <= '0;
            r_gain_p    <= '0;
            r_gain_i    <= '0;
            r_gain_d    <= '0;
            r_drive_max <= espc_pkg::DRIVE_MAX_RST;
            r_drive_min <= espc_pkg::DRIVE_MIN_RST;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_bit   <= n_bit;
            if (r_state == espc_pkg::ST_ERR) begin
                r_sum  <= w_sum_sat;
                r_prev <= w_err;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    espc_pkg::CFG_TARGET:    r_target    <= i_cfg_data[TgtW-1:0];
                    espc_pkg::CFG_GAIN_P:    r_gain_p    <= i_cfg_data[GainW-1:0];
                    espc_pkg::CFG_GAIN_I:    r_gain_i    <= i_cfg_data[GainW-1:0];
                    espc_pkg::CFG_GAIN_D:    r_gain_d    <= i_cfg_data[GainW-1:0];
                    espc_pkg::CFG_DRIVE_MAX: r_drive_max <= i_cfg_data[DrvW-1:0];
                    espc_pkg::CFG_DRIVE_MIN: r_drive_min <= i_cfg_data[DrvW-1:0];
                    default:                 r_target    <= r_target;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        if (r_state == espc_pkg::ST_ERR) begin
            r_speed <= w_speed;
            r_diff  <= w_diff;
        end
        if (w_out_load) begin
            r_drive_out   <= w_drive;
            r_speed_out   <= r_speed;
            r_clamped_out <= w_clamp;
        end
    end

    // checks
    `ESPC_ASSERT_NEXT(a_accept_starts_speed, i_clk, i_rst_n, w_in_accept,
        (r_state == espc_pkg::ST_SPEED) && (r_bit == '0), "accepted word did not start speed")
    `ESPC_ASSERT_NEXT(a_mul_ends_in_round, i_clk, i_rst_n,
        (r_state == espc_pkg::ST_MUL) && (r_phase == espc_pkg::PH_D) && w_bit_last,
        r_state == espc_pkg::ST_ROUND, "last gain bit did not lead to rounding")
    `ESPC_ASSERT_NOW(a_valid_from_out, i_clk, i_rst_n, $rose(o_out_valid),
        $past(r_state) == espc_pkg::ST_OUT, "output word appeared outside the final stage")
    `ESPC_ASSERT_NOW(a_clamp_at_limit, i_clk, i_rst_n, o_out_valid && o_clamped,
        (o_drive_value == r_drive_max) || (o_drive_value == r_drive_min),
        "clamp flag set on a drive away from both limits")

endmodule

`default_nettype wire

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for encoder_speed_pid_controller. A table of directed
// words (reset values, fold edges, clamp corners, crossed limits, ignored
// register indexes) runs first. Random register settings with random count
// words follow, and a short soak runs the integrator hard negative.
// Every accepted count word is run through a PID model kept in the bench;
// each output word is compared field by field with the oldest prediction.
// Both channels see random valid gaps and stalls outside the gap-free phases.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FOLD_LIMIT     = 500;
    localparam int SPEED_SCALE_Q8 = 340;

    localparam int RANDOM_PHASES    = 6;
    localparam int WORDS_PER_PHASE  = 110;
    localparam int SOAK_WORDS       = 64;
    localparam int QUIET_LIMIT      = 1000;   // cycles with work pending and no handshake
    localparam int IDLE_GUARD       = 4;
    localparam int TAIL_CYCLES      = 80;     // quiet tail after the last word drains
    localparam int PAD_W            = espc_pkg::CFG_DATA_W - espc_pkg::DRV_W;

    localparam logic [espc_pkg::CNT_W-1:0]      CNT_MAX       = '1;
    localparam logic [espc_pkg::CFG_IDX_W-1:0]  CFG_SPARE_6   = 3'd6;
    localparam logic [espc_pkg::CFG_IDX_W-1:0]  CFG_SPARE_7   = 3'd7;
    localparam logic [espc_pkg::CFG_DATA_W-1:0] TARGET_TOP    = 26'h1FFFFFF;
    localparam logic [espc_pkg::CFG_DATA_W-1:0] TARGET_BOTTOM = 26'h2000000;
    localparam int     SPEED_TOP  = (65535 - 501) * SPEED_SCALE_Q8;
    localparam longint SPEED_CEIL = (longint'(1) << espc_pkg::SPEED_W) - 1;
    localparam longint DRIVE_DIV  = longint'(1) << espc_pkg::FRAC_W;

    // one output word
    typedef struct packed {
        logic signed [espc_pkg::DRV_W-1:0] drive;
        logic [espc_pkg::SPEED_W-1:0]      speed;
        logic                              clamped;
    } t_drive_word;

    // typed-in expectation travelling with a count word
    typedef struct packed {
        logic        known;
        t_drive_word word;
    } t_count_hint;

    typedef enum logic {ROW_REG, ROW_WORD} t_row_kind;

    // directed row: register write (idx, value) or count word (value)
    typedef struct packed {
        t_row_kind                        kind;
        logic [espc_pkg::CFG_IDX_W-1:0]   idx;
        logic [espc_pkg::CFG_DATA_W-1:0]  value;
        logic                             known;
        t_drive_word                      word;
    } t_stim_row;

    logic                              i_clk            = 1'b0;
    logic                              i_rst_n          = 1'b0;
    logic                              i_cfg_we         = 1'b0;
    logic [espc_pkg::CFG_IDX_W-1:0]    i_cfg_idx        = '0;
    logic [espc_pkg::CFG_DATA_W-1:0]   i_cfg_data       = '0;
    logic                              i_in_valid       = 1'b0;
    logic [espc_pkg::CNT_W-1:0]        i_encoder_count  = '0;
    logic                              i_out_stall      = 1'b0;
    logic                              o_in_stall;
    logic                              o_out_valid;
    logic signed [espc_pkg::DRV_W-1:0] o_drive_value;
    logic [espc_pkg::SPEED_W-1:0]      o_measured_speed;
    logic                              o_clamped;

    // model copy of the registers and loop state
    logic signed [espc_pkg::TGT_W-1:0] reg_target    = '0;
    logic [espc_pkg::GAIN_W-1:0]       reg_gain_p    = '0;
    logic [espc_pkg::GAIN_W-1:0]       reg_gain_i    = '0;
    logic [espc_pkg::GAIN_W-1:0]       reg_gain_d    = '0;
    logic signed [espc_pkg::DRV_W-1:0] reg_drive_max = espc_pkg::DRIVE_MAX_RST;
    logic signed [espc_pkg::DRV_W-1:0] reg_drive_min = espc_pkg::DRIVE_MIN_RST;
    logic signed [espc_pkg::SUM_W-1:0] integ         = '0;
    logic signed [espc_pkg::ERR_W-1:0] last_err      = '0;

    t_drive_word pending_drives [$];
    t_count_hint count_hint  = '0;
    bit          idle_on     = 1'b1;
    int          fail_count  = 0;
    int          quiet_cycles = 0;
    int          stall_left  = 0;

    localparam int N_DIRECTED = 39;
    t_stim_row directed_rows [N_DIRECTED] = '{
        // reset values: all gains zero, so drive is 0 and only speed moves
        '{ROW_WORD, espc_pkg::CFG_TARGET, 26'd0,     1'b1, '{16'sd0, 25'd0,        1'b0}},
        '{ROW_WORD, espc_pkg::CFG_TARGET, 26'd500,   1'b1, '{16'sd0, 25'd170000,   1'b0}},
        '{ROW_WORD, espc_pkg::CFG_TARGET, 26'd501,   1'b1, '{16'sd0, 25'd22111560, 1'b0}},
        '{ROW_WORD, espc_pkg::CFG_TARGET, 26'd65535, 1'b1, '{16'sd0, 25'd0,        1'b0}},
        '{ROW_WORD, espc_pkg::CFG_TARGET, 26'd65534, 1'b1, '{16'sd0, 25'd340,      1'b0}},
        '{ROW_WORD, espc_pkg::CFG_TARGET, 26'h000AAAA, 1'b0, '0},
        '{ROW_WORD, espc_pkg::CFG_TARGET, 26'h0005555, 1'b0, '0},
        // both limits at zero: equality still counts as clamped
        '{ROW_REG,  espc_pkg::CFG_DRIVE_MAX, 26'd0, 1'b0, '0},
        '{ROW_REG,  espc_pkg::CFG_DRIVE_MIN, 26'd0, 1'b0, '0},
        '{ROW_WORD, espc_pkg::CFG_TARGET, 26'd100,   1'b1, '{16'sd0, 25'd34000,    1'b1}},
        // crossed limits, drive above max
        '{ROW_REG,  espc_pkg::CFG_DRIVE_MAX, 26'h3FFFF9C, 1'b0, '0},
        '{ROW_REG,  espc_pkg::CFG_DRIVE_MIN, 26'd100,     1'b0, '0},
        '{ROW_WORD, espc_pkg::CFG_TARGET, 26'd7, 1'b1, '{-16'sd100, 25'd2380, 1'b1}},
        // crossed limits, drive below max falls to min
        '{ROW_REG,  espc_pkg::CFG_DRIVE_MAX, 26'd100, 1'b0, '0},
        '{ROW_REG,  espc_pkg::CFG_DRIVE_MIN, 26'd200, 1'b0, '0},
        '{ROW_WORD, espc_pkg::CFG_TARGET, 26'd7, 1'b1, '{16'sd200, 25'd2380, 1'b1}},
        // writes to unused indexes must change nothing
        '{ROW_REG,  CFG_SPARE_6, 26'h3FFFFFF, 1'b0, '0},
        '{ROW_REG,  CFG_SPARE_7, 26'h3FFFFFF, 1'b0, '0},
        '{ROW_WORD, espc_pkg::CFG_TARGET, 26'd7, 1'b1, '{16'sd200, 25'd2380, 1'b1}},
        // top target with unity P gain saturates the drive high
        '{ROW_REG,  espc_pkg::CFG_DRIVE_MAX, 26'h0007FFF, 1'b0, '0},
        '{ROW_REG,  espc_pkg::CFG_DRIVE_MIN, 26'h3FF8000, 1'b0, '0},
        '{ROW_REG,  espc_pkg::CFG_TARGET,    TARGET_TOP,  1'b0, '0},
        '{ROW_REG,  espc_pkg::CFG_GAIN_P,    26'h0000100, 1'b0, '0},
        '{ROW_WORD, espc_pkg::CFG_TARGET, 26'd0, 1'b1, '{16'sd32767, 25'd0, 1'b1}},
        // full gains, bottom target
        '{ROW_REG,  espc_pkg::CFG_GAIN_I,    26'h000FFFF,   1'b0, '0},
        '{ROW_REG,  espc_pkg::CFG_GAIN_D,    26'h000FFFF,   1'b0, '0},
        '{ROW_REG,  espc_pkg::CFG_GAIN_P,    26'h000FFFF,   1'b0, '0},
        '{ROW_REG,  espc_pkg::CFG_TARGET,    TARGET_BOTTOM, 1'b0, '0},
        '{ROW_WORD, espc_pkg::CFG_TARGET,    26'd501,       1'b0, '0},
        '{ROW_WORD, espc_pkg::CFG_TARGET,    26'd0,         1'b0, '0},
        '{ROW_WORD, espc_pkg::CFG_TARGET,    26'd65535,     1'b0, '0},
        '{ROW_WORD, espc_pkg::CFG_TARGET,    26'd250,       1'b0, '0},
        // mild gains; the first word's large error step clamps, then the drive lands inside the limits
        '{ROW_REG,  espc_pkg::CFG_TARGET,    26'd0,         1'b0, '0},
        '{ROW_REG,  espc_pkg::CFG_GAIN_P,    26'h0000100,   1'b0, '0},
        '{ROW_REG,  espc_pkg::CFG_GAIN_I,    26'h0000001,   1'b0, '0},
        '{ROW_REG,  espc_pkg::CFG_GAIN_D,    26'h0000080,   1'b0, '0},
        '{ROW_WORD, espc_pkg::CFG_TARGET,    26'd100,       1'b0, '0},
        '{ROW_WORD, espc_pkg::CFG_TARGET,    26'd200,       1'b0, '0},
        '{ROW_WORD, espc_pkg::CFG_TARGET,    26'd65500,     1'b0, '0}
    };

    encoder_speed_pid_controller #(
        .FOLD_LIMIT     (FOLD_LIMIT),
        .SPEED_SCALE_Q8 (SPEED_SCALE_Q8)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_encoder_count  (i_encoder_count),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_drive_value    (o_drive_value),
        .o_measured_speed (o_measured_speed),
        .o_clamped        (o_clamped)
    );

    always #4 i_clk = ~i_clk;

    // PID step: fold, speed, error, saturating integrator, gains, clamp
    function automatic t_drive_word pid_step(input logic [espc_pkg::CNT_W-1:0] cnt);
        logic [espc_pkg::CNT_W-1:0] folded;
        longint           speed;
        longint           err;
        longint           acc;
        longint           effort;
        t_drive_word      res;
        folded = (cnt > FOLD_LIMIT) ? CNT_MAX - cnt : cnt;
        speed  = longint'(folded) * SPEED_SCALE_Q8;
        if (speed > SPEED_CEIL) speed = SPEED_CEIL;
        err = longint'(reg_target) - speed;
        acc = longint'(integ) + err;
        if (acc > longint'(espc_pkg::SUM_MAX))      acc = longint'(espc_pkg::SUM_MAX);
        else if (acc < longint'(espc_pkg::SUM_MIN)) acc = longint'(espc_pkg::SUM_MIN);
        integ  = acc[espc_pkg::SUM_W-1:0];
        effort = longint'(reg_gain_p) * err
               + longint'(reg_gain_i) * acc
               + longint'(reg_gain_d) * (err - longint'(last_err));
        last_err = err[espc_pkg::ERR_W-1:0];
        effort   = effort / DRIVE_DIV;  // truncates toward zero
        res.clamped = 1'b1;
        if (effort >= longint'(reg_drive_max))      res.drive = reg_drive_max;
        else if (effort <= longint'(reg_drive_min)) res.drive = reg_drive_min;
        else begin
            res.drive   = effort[espc_pkg::DRV_W-1:0];
            res.clamped = 1'b0;
        end
        res.speed = speed[espc_pkg::SPEED_W-1:0];
        return res;
    endfunction

    function automatic int draw_wait();
        return idle_on ? int'($urandom_range(0, 15)) : 0;
    endfunction

    function automatic logic [espc_pkg::CFG_DATA_W-1:0] with_junk(
        input logic [espc_pkg::DRV_W-1:0] v);
        // upper bits of the write data are don't-care for 16-bit registers
        return {PAD_W'($urandom), v};
    endfunction

    function automatic logic [espc_pkg::GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            2, 3:    return espc_pkg::GAIN_W'($urandom_range(0, 16'h03FF));
            default: return espc_pkg::GAIN_W'($urandom);
        endcase
    endfunction

    function automatic logic [espc_pkg::CNT_W-1:0] pick_count();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return espc_pkg::CNT_W'($urandom_range(0, FOLD_LIMIT));
            4, 5:       return espc_pkg::CNT_W'($urandom_range(65535 - FOLD_LIMIT, 65535));
            6:          return espc_pkg::CNT_W'($urandom_range(FOLD_LIMIT, FOLD_LIMIT + 1));
            default:    return espc_pkg::CNT_W'($urandom);
        endcase
    endfunction

    function automatic void flag(input string msg);
        fail_count++;
        $display("%0t: %s", $time, msg);
    endfunction

    // let every predicted word come back, then a few quiet cycles
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_drives.size() != 0) @(posedge i_clk);
        repeat (IDLE_GUARD) @(posedge i_clk);
    endtask

    // register write, only with the block idle
    task automatic set_reg(input logic [espc_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [espc_pkg::CFG_DATA_W-1:0] data);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            espc_pkg::CFG_TARGET:    reg_target    = data[espc_pkg::TGT_W-1:0];
            espc_pkg::CFG_GAIN_P:    reg_gain_p    = data[espc_pkg::GAIN_W-1:0];
            espc_pkg::CFG_GAIN_I:    reg_gain_i    = data[espc_pkg::GAIN_W-1:0];
            espc_pkg::CFG_GAIN_D:    reg_gain_d    = data[espc_pkg::GAIN_W-1:0];
            espc_pkg::CFG_DRIVE_MAX: reg_drive_max = data[espc_pkg::DRV_W-1:0];
            espc_pkg::CFG_DRIVE_MIN: reg_drive_min = data[espc_pkg::DRV_W-1:0];
            default:                 ;
        endcase
    endtask

    // one count word; valid stays high into the next word when no gap is drawn
    task automatic send_count(input logic [espc_pkg::CNT_W-1:0] cnt,
                              input t_count_hint hint);
        int gap;
        gap = draw_wait();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_encoder_count <= cnt;
        count_hint      <= hint;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic load_random_setting();
        logic signed [espc_pkg::DRV_W-1:0] a;
        logic signed [espc_pkg::DRV_W-1:0] b;
        logic signed [espc_pkg::DRV_W-1:0] hi;
        logic signed [espc_pkg::DRV_W-1:0] lo;
        logic [espc_pkg::CFG_DATA_W-1:0]   tgt;
        a = espc_pkg::DRV_W'($urandom);
        b = espc_pkg::DRV_W'($urandom);
        case ($urandom_range(0, 3))
            0: begin
                hi = espc_pkg::DRIVE_MAX_RST;
                lo = espc_pkg::DRIVE_MIN_RST;
            end
            1: begin  // crossed
                hi = (a < b) ? a : b;
                lo = (a < b) ? b : a;
            end
            default: begin
                hi = (a < b) ? b : a;
                lo = (a < b) ? a : b;
            end
        endcase
        case ($urandom_range(0, 5))
            0, 1:    tgt = espc_pkg::CFG_DATA_W'($urandom_range(0, SPEED_TOP));
            2:       tgt = espc_pkg::CFG_DATA_W'(
                               $urandom_range(0, FOLD_LIMIT * SPEED_SCALE_Q8));
            3:       tgt = espc_pkg::CFG_DATA_W'($urandom);
            4:       tgt = TARGET_TOP;
            default: tgt = TARGET_BOTTOM;
        endcase
        set_reg(espc_pkg::CFG_TARGET, tgt);
        set_reg(espc_pkg::CFG_GAIN_P, with_junk(pick_gain()));
        set_reg(espc_pkg::CFG_GAIN_I, with_junk(pick_gain()));
        set_reg(espc_pkg::CFG_GAIN_D, with_junk(pick_gain()));
        set_reg(espc_pkg::CFG_DRIVE_MAX, with_junk(hi));
        set_reg(espc_pkg::CFG_DRIVE_MIN, with_junk(lo));
    endtask

    // output side back-pressure, drawn per accepted word
    always @(posedge i_clk) begin
        int w;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (o_out_valid && !i_out_stall) begin
            w = draw_wait();
            stall_left  <= w;
            i_out_stall <= (w != 0);
        end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else begin
            stall_left  <= 0;
            i_out_stall <= 1'b0;
        end
    end

    // predict on input handshakes, check on output handshakes, watchdog
    always @(posedge i_clk) begin
        t_drive_word got;
        t_drive_word want;
        t_drive_word pred;
        bit          moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                got   = {o_drive_value, o_measured_speed, o_clamped};
                if (pending_drives.size() == 0) begin
                    flag($sformatf("output word with none expected: drive %0d speed %0d",
                                   $signed(got.drive), got.speed));
                end else begin
                    want = pending_drives.pop_front();
                    if (got.drive !== want.drive)
                        flag($sformatf("drive_value expected %0d got %0d",
                                       $signed(want.drive), $signed(got.drive)));
                    if (got.speed !== want.speed)
                        flag($sformatf("measured_speed expected %0d got %0d",
                                       want.speed, got.speed));
                    if (got.clamped !== want.clamped)
                        flag($sformatf("clamped expected %0b got %0b",
                                       want.clamped, got.clamped));
                end
            end
            if (i_in_valid && !o_in_stall) begin
                moved = 1'b1;
                pred  = pid_step(i_encoder_count);
                pending_drives.push_back(count_hint.known ? count_hint.word : pred);
            end
            if (moved || !(i_in_valid || pending_drives.size() != 0)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("tb: failure");
                    $finish;
                end
            end
        end
    end

    // stimulus
    initial begin
        t_count_hint no_hint;
        no_hint = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_REG)
                set_reg(directed_rows[r].idx, directed_rows[r].value);
            else
                send_count(directed_rows[r].value[espc_pkg::CNT_W-1:0],
                           '{directed_rows[r].known, directed_rows[r].word});
        end

        // random settings; every third phase runs without gaps or stalls
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            idle_on = (ph % 3 != 0);
            load_random_setting();
            repeat (WORDS_PER_PHASE) send_count(pick_count(), no_hint);
        end

        // integrator soak: largest negative error for a stretch,
        // then a positive error to turn the sum around
        idle_on = 1'b0;
        set_reg(espc_pkg::CFG_TARGET, TARGET_BOTTOM);
        set_reg(espc_pkg::CFG_GAIN_P, '0);
        set_reg(espc_pkg::CFG_GAIN_I, 26'd1);
        set_reg(espc_pkg::CFG_GAIN_D, '0);
        set_reg(espc_pkg::CFG_DRIVE_MAX, with_junk(espc_pkg::DRIVE_MAX_RST));
        set_reg(espc_pkg::CFG_DRIVE_MIN, with_junk(espc_pkg::DRIVE_MIN_RST));
        repeat (SOAK_WORDS) send_count(espc_pkg::CNT_W'(FOLD_LIMIT + 1), no_hint);
        set_reg(espc_pkg::CFG_TARGET, TARGET_TOP);
        repeat (3) send_count('0, no_hint);

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
